[hdl/ev_tcd_pkg.sv]
package ev_tcd_pkg;

  // Configuration register indexes
  localparam logic CFG_MAX_DRIVE_TORQUE   = 1'b0;
  localparam logic CFG_REGEN_BRAKE_TORQUE = 1'b1;

  localparam logic [15:0] MAX_DRIVE_RESET = 16'd35000;
  localparam logic [15:0] REGEN_RESET     = 16'd3000;

  // Q1.15 factor limits
  localparam logic [15:0] Q_ONE      = 16'd32768;
  localparam logic [15:0] TEMP_FLOOR = 16'd9830;   // 0.3
  localparam logic [15:0] SOC_FLOOR  = 16'd6553;   // 0.2

  localparam logic [13:0] PEDAL_FULL = 14'd10000;

  // Reciprocals for the constant divisions (exact over the operand range)
  // speed:  floor(2048*x/75)     = (x*SF_RECIP) >> 18
  // temp:   floor(4096*y/125)    = (y*TF_RECIP) >> 17
  // charge: floor(4096*z/625)    = (z*CF_RECIP) >> 23
  // final:  floor(u/10000)       = (u*U_RECIP)  >> 44
  localparam logic [22:0] SF_RECIP = 23'd7158279;
  localparam logic [22:0] TF_RECIP = 23'd4294968;
  localparam logic [25:0] CF_RECIP = 26'd54975582;
  localparam logic [30:0] U_RECIP  = 31'd1759218605;

  // Stage 1: pedal product, raw factor quotients, regen result
  typedef struct packed {
    logic        drive;
    logic [29:0] pm;
    logic        s_full;
    logic        s_zero;
    logic [15:0] sf_raw;
    logic        t_full;
    logic        t_low;
    logic [15:0] tf_raw;
    logic        c_low;
    logic        c_full;
    logic [15:0] cf_raw;
    logic [16:0] regen;
  } st1_t;

  // Stage 2: pedal product and combined factor
  typedef struct packed {
    logic        drive;
    logic [29:0] pm;
    logic [30:0] gain;
    logic [16:0] regen;
  } st2_t;

  // Stage 3: full product divided by 2^30
  typedef struct packed {
    logic        drive;
    logic [29:0] u;
    logic [16:0] regen;
  } st3_t;

  // Stage 4: final torque
  typedef struct packed {
    logic        drive;
    logic [16:0] torque;
  } st4_t;

endpackage

[hdl/ev_torque_command_derate.sv]
// Torque command with speed, temperature and charge derating.
// Input stream s_axis carries one sample per transaction: pedal position,
// vehicle speed, battery temperature and state of charge. Output stream
// m_axis carries one signed torque command (0.01 Nm) per sample, in order.
// With the pedal pressed the command is the pedal share of max drive torque
// scaled by the speed derate and the lower of the temperature and charge
// derates; with the pedal released it is the negative regen torque, or zero
// when regen is inhibited (high charge, low speed, hot battery).
// Throughput: one sample per cycle while the receiver keeps m_axis_tready
// high. Pipeline: the result reaches m_axis through four register stages
// in order, set by the chain of dependent multiplies: factor reciprocal,
// factor product, torque product, divide-by-10000 reciprocal.
// Each stage advances on its own when the stage after it has room, so
// bubbles close up and s_axis_tready stays high while any stage is free.
// A stalled receiver holds the output register; the pipeline backs up and
// drops tready only when all four stages are full. Nothing is lost.
// Reset clears all valid bits and loads the register defaults
// (max drive torque 350 Nm, regen torque 30 Nm). Write config only when idle.
module ev_torque_command_derate
  import ev_tcd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [15:0] cfg_data_i,

  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,  // pedal_level[13:0], vehicle_speed[25:14],
                                     // battery_temp[37:26], battery_soc[51:38]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata   // torque_command[16:0]
);

  // Configuration registers
  logic [15:0] max_drive_q, max_drive_d;
  logic [15:0] regen_q, regen_d;

  always_comb begin
    max_drive_d = max_drive_q;
    regen_d     = regen_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_MAX_DRIVE_TORQUE:   max_drive_d = cfg_data_i;
        CFG_REGEN_BRAKE_TORQUE: regen_d     = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_drive_q <= MAX_DRIVE_RESET;
      regen_q     <= REGEN_RESET;
    end else begin
      max_drive_q <= max_drive_d;
      regen_q     <= regen_d;
    end
  end

  // Pipeline control: stage k loads when it is empty or stage k+1 can load
  logic [3:0] vld_q, vld_d;
  logic [3:0] rdy;

  assign rdy[3] = !vld_q[3] || m_axis_tready;
  assign rdy[2] = !vld_q[2] || rdy[3];
  assign rdy[1] = !vld_q[1] || rdy[2];
  assign rdy[0] = !vld_q[0] || rdy[1];
  assign s_axis_tready = rdy[0];

  always_comb begin
    vld_d = vld_q;
    if (rdy[0]) vld_d[0] = s_axis_tvalid;
    if (rdy[1]) vld_d[1] = vld_q[0];
    if (rdy[2]) vld_d[2] = vld_q[1];
    if (rdy[3]) vld_d[3] = vld_q[2];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // Input fields
  logic [13:0]        pedal;
  logic [11:0]        speed;
  logic signed [11:0] temp;
  logic [13:0]        soc;

  assign pedal = s_axis_tdata[13:0];
  assign speed = s_axis_tdata[25:14];
  assign temp  = s_axis_tdata[37:26];
  assign soc   = s_axis_tdata[51:38];

  // Stage 1: clamp pedal, operands of the derate ramps, reciprocal multiplies
  st1_t               s1_q, s1_d;
  logic [13:0]        pedal_c;
  logic [11:0]        x_w;
  logic signed [15:0] temp_ext;
  logic signed [15:0] y_w;
  logic [15:0]        z_w;
  logic [33:0]        sf_p;
  logic [32:0]        tf_p;
  logic [38:0]        cf_p;
  logic               regen_off;

  always_comb begin
    pedal_c  = (pedal > PEDAL_FULL) ? PEDAL_FULL : pedal;
    x_w      = 12'd2000 - speed;
    temp_ext = 16'(temp);
    y_w      = 16'sd4500 - temp_ext * 16'sd7;
    z_w      = {2'b00, soc} * 16'd4 - 16'd1000;
    sf_p     = 34'(x_w[10:0]) * 34'(SF_RECIP);
    tf_p     = 33'(y_w[9:0]) * 33'(TF_RECIP);
    cf_p     = 39'(z_w[12:0]) * 39'(CF_RECIP);
    regen_off = (soc >= 14'd9500) || (speed < 12'd50) || (temp > 12'sd550);

    s1_d.drive  = pedal > 14'd1;
    s1_d.pm     = 30'(pedal_c) * 30'(max_drive_q);
    s1_d.s_full = speed <= 12'd800;
    s1_d.s_zero = speed >= 12'd2000;
    s1_d.sf_raw = sf_p[33:18];
    s1_d.t_full = temp <= 12'sd500;
    s1_d.t_low  = temp > 12'sd600;
    s1_d.tf_raw = tf_p[32:17];
    s1_d.c_low  = soc < 14'd500;
    s1_d.c_full = soc >= 14'd1500;
    s1_d.cf_raw = cf_p[38:23];
    s1_d.regen  = regen_off ? 17'd0 : 17'd0 - {1'b0, regen_q};
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0] && s_axis_tvalid) s1_q <= s1_d;
  end

  // Stage 2: pick factors, battery factor = min, combined gain
  st2_t        s2_q, s2_d;
  logic [15:0] sf, tf, cf, bf;

  always_comb begin
    priority if (s1_q.s_full) sf = Q_ONE;
    else if (s1_q.s_zero)     sf = 16'd0;
    else                      sf = s1_q.sf_raw;

    priority if (s1_q.t_full) tf = Q_ONE;
    else if (s1_q.t_low)      tf = TEMP_FLOOR;
    else                      tf = s1_q.tf_raw;

    priority if (s1_q.c_low)  cf = SOC_FLOOR;
    else if (s1_q.c_full)     cf = Q_ONE;
    else                      cf = s1_q.cf_raw;

    bf = (cf < tf) ? cf : tf;

    s2_d.drive = s1_q.drive;
    s2_d.pm    = s1_q.pm;
    s2_d.gain  = 31'(sf) * 31'(bf);
    s2_d.regen = s1_q.regen;
  end

  always_ff @(posedge clk_i) begin
    if (rdy[1] && vld_q[0]) s2_q <= s2_d;
  end

  // Stage 3: full product, drop the 2^30 factor scaling
  st3_t        s3_q, s3_d;
  logic [60:0] full_p;

  always_comb begin
    full_p     = 61'(s2_q.pm) * 61'(s2_q.gain);
    s3_d.drive = s2_q.drive;
    s3_d.u     = full_p[59:30];
    s3_d.regen = s2_q.regen;
  end

  always_ff @(posedge clk_i) begin
    if (rdy[2] && vld_q[1]) s3_q <= s3_d;
  end

  // Stage 4: divide by 10000, select drive or regen
  st4_t        s4_q, s4_d;
  logic [60:0] q_p;

  always_comb begin
    q_p         = 61'(s3_q.u) * 61'(U_RECIP);
    s4_d.drive  = s3_q.drive;
    s4_d.torque = s3_q.drive ? {1'b0, q_p[59:44]} : s3_q.regen;
  end

  always_ff @(posedge clk_i) begin
    if (rdy[3] && vld_q[2]) s4_q <= s4_d;
  end

  assign m_axis_tvalid = vld_q[3];
  assign m_axis_tdata  = {7'd0, s4_q.torque};

`ifndef NO_ASSERTIONS
  // Combined gain is a product of two Q1.15 factors, never above one
  a_gain_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[1] |-> s2_q.gain <= 31'h4000_0000)
    else $error("gain above unity");

  // Drive results are never negative
  a_drive_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[3] && s4_q.drive |-> !s4_q.torque[16])
    else $error("negative drive torque");

  // Regen results are zero or negative
  a_regen_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[3] && !s4_q.drive |-> s4_q.torque[16] || s4_q.torque == 17'd0)
    else $error("positive regen torque");

  // A free first stage always accepts
  a_accept_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !vld_q[0] |-> s_axis_tready)
    else $error("tready low with empty input stage");

  // A result taken with nothing behind it leaves the output empty
  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[3] && m_axis_tready && !vld_q[2] |=> !m_axis_tvalid)
    else $error("result repeated");
`endif

endmodule

[bench/ev_torque_command_derate_tb.sv]
`timescale 1ns / 100ps

module ev_torque_command_derate_tb;
  import ev_tcd_pkg::*;

  // Worst case is roughly 1600 samples, each meeting a long sender gap and a
  // long receiver stall, well under this bound.
  localparam int CycleLimit  = 1000000;
  localparam int DrainCycles = 8;
  localparam int RandPhases  = 5;
  localparam int PhaseItems  = 310;

  typedef struct {
    logic [13:0]        pedal;
    logic [11:0]        speed;
    logic signed [11:0] temp;
    logic [13:0]        soc;
  } drive_sample_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic        cfg_idx_i;
  logic [15:0] cfg_data_i;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [55:0] s_axis_tdata  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;

  drive_sample_t sample_queue[$];
  logic [16:0]   expected_torque[$];
  logic [15:0]   drive_lim_cfg;
  logic [15:0]   regen_lim_cfg;
  int            errors         = 0;
  int            samples_queued = 0;
  int            samples_taken  = 0;
  int            cycles         = 0;
  bit            sample_taken   = 1'b0;
  int            send_gap       = 0;
  int            send_calm      = 0;
  int            stall_left     = 0;
  int            stall_calm     = 0;

  ev_torque_command_derate dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Expected torque for one sample under the current register settings
  function automatic logic [16:0] derated_torque(drive_sample_t s);
    int          pedal;
    int          spd;
    int          tmp;
    int          chg;
    int          spd_f;
    int          tmp_f;
    int          chg_f;
    int          batt_f;
    logic [63:0] prod;
    logic [63:0] scaled;
    pedal = s.pedal;
    spd   = s.speed;
    tmp   = s.temp;
    chg   = s.soc;
    if (pedal > 1) begin
      if (pedal > 10000) pedal = 10000;
      // speed derate: flat to 80 km/h, linear to zero at 200 km/h
      if (spd <= 800) spd_f = 32768;
      else if (spd >= 2000) spd_f = 0;
      else spd_f = (32768 * (2000 - spd)) / 1200;
      // temperature derate: 1.0 up to 50 C, down to 0.3 past 60 C
      if (tmp <= 500) tmp_f = 32768;
      else if (tmp > 600) tmp_f = 9830;
      else tmp_f = (32768 * (1000 - 7 * (tmp - 500))) / 1000;
      // charge derate: 0.2 below 5 %, up to 1.0 at 15 %
      if (chg < 500) chg_f = 6553;
      else if (chg >= 1500) chg_f = 32768;
      else chg_f = (32768 * (1000 + 4 * (chg - 500))) / 5000;
      batt_f = (chg_f < tmp_f) ? chg_f : tmp_f;
      prod   = 64'(pedal);
      prod   = prod * 64'(drive_lim_cfg);
      prod   = prod * 64'(spd_f);
      prod   = prod * 64'(batt_f);
      scaled = (prod / 64'd10000) >> 30;
      return scaled[16:0];
    end
    // coasting: regen unless inhibited
    if (chg >= 9500 || spd < 50 || tmp > 550) return 17'd0;
    return 17'd0 - {1'b0, regen_lim_cfg};
  endfunction

  // Idle length: mostly zero or short, a few long, with calm stretches
  function automatic int pick_delay(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      calm = $urandom_range(20, 80);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic drive_sample_t rand_sample();
    drive_sample_t s;
    int            r;
    r = $urandom_range(0, 99);
    if (r < 15) s.pedal = 14'($urandom_range(0, 1));
    else if (r < 25) s.pedal = 14'($urandom);
    else s.pedal = 14'($urandom_range(2, 10000));
    r = $urandom_range(0, 99);
    if (r < 15) s.speed = 12'($urandom);
    else if (r < 35) s.speed = 12'($urandom_range(0, 120));
    else s.speed = 12'($urandom_range(0, 3000));
    r = $urandom_range(0, 99);
    if (r < 15) s.temp = 12'($urandom);
    else if (r < 55) s.temp = 12'($urandom_range(400, 700));
    else s.temp = 12'(int'($urandom_range(0, 1900)) - 400);
    r = $urandom_range(0, 99);
    if (r < 15) s.soc = 14'($urandom);
    else if (r < 40) s.soc = 14'($urandom_range(300, 1700));
    else if (r < 55) s.soc = 14'($urandom_range(9300, 9700));
    else s.soc = 14'($urandom_range(0, 10000));
    return s;
  endfunction

  task automatic add_sample(int pedal, int spd, int tmp, int chg);
    drive_sample_t s;
    s.pedal = 14'(pedal);
    s.speed = 12'(spd);
    s.temp  = 12'(tmp);
    s.soc   = 14'(chg);
    sample_queue.push_back(s);
    samples_queued++;
  endtask

  task automatic write_limits(logic [15:0] drive_lim, logic [15:0] regen_lim);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_MAX_DRIVE_TORQUE;
    cfg_data_i <= drive_lim;
    @(negedge clk_i);
    cfg_idx_i  <= CFG_REGEN_BRAKE_TORQUE;
    cfg_data_i <= regen_lim;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    drive_lim_cfg = drive_lim;
    regen_lim_cfg = regen_lim;
  endtask

  // Wait until every queued sample went in and every torque came back
  task automatic wait_drained();
    do @(negedge clk_i);
    while (samples_taken != samples_queued || expected_torque.size() != 0);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic report_mismatch(string what);
    $display("torque_command mismatch at cycle %0d: %s", cycles, what);
    errors++;
  endtask

  // Test sequence
  initial begin
    int phase;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CFG_MAX_DRIVE_TORQUE;
    cfg_data_i    = '0;
    drive_lim_cfg = MAX_DRIVE_RESET;
    regen_lim_cfg = REGEN_RESET;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed corners at reset defaults
    add_sample(0, 1000, 250, 5000);      // regen
    add_sample(1, 1000, 250, 5000);      // pedal at threshold still regen
    add_sample(0, 49, 250, 5000);        // too slow for regen
    add_sample(0, 50, 550, 9499);        // regen at all inhibit edges
    add_sample(0, 50, 551, 5000);        // hot battery inhibits regen
    add_sample(0, 500, 250, 9500);       // full battery inhibits regen
    add_sample(2, 0, 0, 10000);          // smallest drive pedal
    add_sample(10000, 800, 500, 1500);   // all factors at unity
    add_sample(16383, 801, 501, 1499);   // pedal saturates
    add_sample(10000, 1999, 600, 500);
    add_sample(10000, 2000, 601, 499);   // speed derate reaches zero
    add_sample(10000, 4095, -2048, 0);
    add_sample(5000, 1200, 2047, 16383);
    add_sample(10000, 0, -400, 16383);
    add_sample(8191, 2730, 1500, 499);
    add_sample(9999, 1000, 550, 1000);
    add_sample(0, 4095, -2048, 0);
    add_sample(1, 50, 2047, 9500);
    add_sample(10000, 100, 560, 800);    // temp and charge derates compete
    add_sample(0, 3000, 1500, 10000);
    add_sample(12345, 1500, 520, 1200);
    add_sample(10000, 0, 600, 499);      // both derates at their floors
    add_sample(0, 50, -400, 0);
    wait_drained();

    for (phase = 0; phase < RandPhases; phase++) begin
      case (phase)
        0:       write_limits(16'hFFFF, 16'h0000);
        1:       write_limits(16'h0000, 16'hFFFF);
        2:       write_limits(16'hFFFF, 16'hFFFF);
        3:       write_limits(16'd1, 16'd1);
        default: write_limits(16'($urandom), 16'($urandom));
      endcase
      repeat (PhaseItems) begin
        sample_queue.push_back(rand_sample());
        samples_queued++;
      end
      wait_drained();
    end

    if (errors == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Sample driver: next transaction once the current one is taken
  always @(negedge clk_i) begin : sample_driver
    drive_sample_t nxt;
    if (rst_ni && (!s_axis_tvalid || sample_taken)) begin
      if (send_gap > 0) begin
        s_axis_tvalid <= 1'b0;
        send_gap--;
      end else if (sample_queue.size() != 0) begin
        nxt = sample_queue.pop_front();
        s_axis_tdata  <= {4'b0, nxt.soc, nxt.temp, nxt.speed, nxt.pedal};
        s_axis_tvalid <= 1'b1;
        send_gap = pick_delay(send_calm);
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Receiver backpressure
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left--;
    end else begin
      m_axis_tready <= 1'b1;
      stall_left = pick_delay(stall_calm);
    end
  end

  // Input side: predict torque for each accepted sample
  always @(posedge clk_i) begin : sample_intake
    drive_sample_t got;
    sample_taken = rst_ni && s_axis_tvalid && s_axis_tready;
    if (sample_taken) begin
      got.pedal = s_axis_tdata[13:0];
      got.speed = s_axis_tdata[25:14];
      got.temp  = s_axis_tdata[37:26];
      got.soc   = s_axis_tdata[51:38];
      expected_torque.push_back(derated_torque(got));
      samples_taken++;
    end
  end

  // Output side: compare in order
  always @(posedge clk_i) begin : torque_check
    logic [16:0] want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_torque.size() == 0) begin
        report_mismatch($sformatf("unexpected %0d", $signed(m_axis_tdata[16:0])));
      end else begin
        want = expected_torque.pop_front();
        if (m_axis_tdata[16:0] !== want) begin
          report_mismatch($sformatf("got %0d, expected %0d",
                                    $signed(m_axis_tdata[16:0]), $signed(want)));
        end
      end
    end
  end

  // Run-length guard
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

endmodule
